>>> hdl/ctia_pkg.sv
// ----------------------------------------------------------------------------
// ctia_pkg
// shared types and constants of the initializable array: entry layout,
// operation codes and the sequencer states
// ----------------------------------------------------------------------------
package ctia_pkg;

	localparam int ENTRIES = 1024;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = $clog2(ENTRIES) + 1;
	localparam int DATA_W  = 32;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENTRY,
		ST_LIST
	} state_t;

	// one word of the entry memory: back pointer above the stored data
	typedef struct packed {
		logic [IDX_W-1:0]         bp;
		logic signed [DATA_W-1:0] data;
	} entry_t;

endpackage

>>> hdl/ctia_ram.sv
// ----------------------------------------------------------------------------
// ctia_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ctia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	// two-state storage, stale contents are arbitrary but never unknown
	bit [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/constant_time_initialized_array.sv
// a read result is registered in ST_LIST, which waits for a free output slot
// accesses do not overlap (s_tready only in ST_IDLE): each needs the dependent
//   reads of entry memory (back pointer), then list memory, before write-back
// reset clears state, output valid, registration count and default value, so
//   the array reads as empty at once; the memories are never swept
// ----------------------------------------------------------------------------
// constant_time_initialized_array
// array of 32-bit entries that reads as a default value until written,
// validity checked through back pointers and a registration list
// ----------------------------------------------------------------------------
module constant_time_initialized_array
	import ctia_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              default_value_we,
	input  logic [DATA_W-1:0] default_value,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // index [9:0], write_value [41:10]
	input  logic              s_tuser,   // operation [0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata    // read_data [31:0]
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  default_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;

	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [DATA_W-1:0]  val_q;

	logic               in_xfer;
	logic               out_free;
	logic               done;

	logic               ent_re, ent_we;
	logic [IDX_W-1:0]   ent_raddr;
	entry_t             ent_rd, ent_wd;
	logic               lst_re, lst_we;
	logic [IDX_W-1:0]   lst_rd;

	logic               valid_hit;
	logic               full;
	logic               count_inc;
	logic               out_load;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full     = (count_q == CNT_W'(ENTRIES));
	assign valid_hit = ({1'b0, ent_rd.bp} < count_q) && (lst_rd == idx_q);

	assign ent_raddr = s_tdata[IDX_W-1:0];
	assign ent_wd.bp   = (valid_hit || full) ? ent_rd.bp : count_q[IDX_W-1:0];
	assign ent_wd.data = val_q;

	ctia_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(idx_q),
		.wdata(ent_wd),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rd)
	);

	ctia_ram #(
		.WIDTH(IDX_W),
		.DEPTH(ENTRIES)
	) u_list_ram (
		.clk  (clk),
		.we   (lst_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(idx_q),
		.re   (lst_re),
		.raddr(ent_rd.bp),
		.rdata(lst_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_ENTRY;
				end
			end
			ST_ENTRY: state_d = ST_LIST;
			ST_LIST: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		ent_re    = 1'b0;
		lst_re    = 1'b0;
		ent_we    = 1'b0;
		lst_we    = 1'b0;
		count_inc = 1'b0;
		out_load  = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ent_re   = s_tvalid;
			end
			ST_ENTRY: lst_re = 1'b1;
			ST_LIST: begin
				if (op_q == OP_WRITE) begin
					done      = 1'b1;
					ent_we    = 1'b1;
					lst_we    = !valid_hit && !full;
					count_inc = !valid_hit && !full;
				end else begin
					done     = out_free;
					out_load = out_free;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			default_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (default_value_we) begin
				default_q <= default_value;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= op_t'(s_tuser);
			idx_q <= s_tdata[IDX_W-1:0];
			val_q <= s_tdata[IDX_W+DATA_W-1:IDX_W];
		end
		if (out_load) begin
			out_data_q <= valid_hit ? ent_rd.data : default_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("registration count beyond array size");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!count_inc |=> $stable(count_q))
		else $error("registration count changed without a registering write");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_LIST && $past(op_q) == OP_READ))
		else $error("result appeared without a read lookup");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ENTRY |=> state_q == ST_LIST)
		else $error("list lookup skipped");

endmodule
